[hdl/sti_pkg.sv]
// shared types, constants and helpers for the string to integer unit
package sti_pkg;

  localparam int MAX_BASE   = 16;
  localparam int CHAR_W     = 8;
  localparam int DIG_W      = 4;
  localparam int LEN_W      = 5;
  localparam int ACC_W      = 32;
  localparam int HALF_W     = 64;
  localparam int APB_DATA_W = 64;
  localparam int APB_ADDR_W = 5;
  localparam int REG_IDX_W  = 2;

  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ALPHA_LOW,
    REG_ALPHA_HIGH,
    REG_ALPHA_LEN
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BAD_ALPHABET,
    ST_STRAY
  } status_t;

  typedef logic [MAX_BASE-1:0][CHAR_W-1:0] alphabet_t;

  typedef struct packed {
    logic             term;
    logic             space;
    logic             plus;
    logic             minus;
    logic             hit;
    logic [DIG_W-1:0] digit;
  } char_class_t;

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return ((c >= CHAR_TAB) && (c <= CHAR_CR)) || (c == CHAR_SPACE);
  endfunction

endpackage

[hdl/string_to_int_any_base_unit.sv]
// top level: byte stream in, signed integer with status out, alphabet registers
// Takes one string byte per cycle and gives one result per string; the result
// word is loaded into the output register when its zero terminator leaves the
// input register, provided no earlier result is still held. Each byte passes
// from an input register through one classify step and one 32 by 5 bit
// multiply-add into the parse state, so back-to-back bytes sustain one per
// cycle; a terminator waits only while an earlier result has not been taken.
// Alphabet registers sit at byte addresses 0, 8 and 16 and may be changed only
// while no string is in flight; their validity check is registered from them.
module string_to_int_any_base_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [sti_pkg::CHAR_W-1:0]     in_char_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [sti_pkg::ACC_W-1:0] out_value,
  output logic [1:0]                     out_status,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sti_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [sti_pkg::APB_DATA_W-1:0] pwdata,
  output logic [sti_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  typedef enum logic [1:0] {
    PH_SPACE,
    PH_SIGN,
    PH_DIGIT,
    PH_STRAY
  } phase_t;

  sti_pkg::alphabet_t          alphabet;
  logic [sti_pkg::LEN_W-1:0]   alpha_len;
  logic                        alpha_ok;
  sti_pkg::char_class_t        cls;

  logic                        in_vld_r;
  logic                        in_vld_nxt;
  logic [sti_pkg::CHAR_W-1:0]  in_byte_r;
  phase_t                      phase_r;
  phase_t                      phase_nxt;
  logic [sti_pkg::ACC_W-1:0]   acc_r;
  logic [sti_pkg::ACC_W-1:0]   acc_nxt;
  logic                        neg_r;
  logic                        neg_nxt;
  logic                        out_vld_r;
  logic                        out_vld_nxt;
  logic [sti_pkg::ACC_W-1:0]   out_value_r;
  logic [sti_pkg::ACC_W-1:0]   out_value_nxt;
  sti_pkg::status_t            out_status_r;
  sti_pkg::status_t            out_status_nxt;
  logic                        fire;
  logic                        emit;
  logic                        in_take;
  logic [sti_pkg::ACC_W-1:0]   mac;

  sti_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .alphabet  (alphabet),
    .alpha_len (alpha_len),
    .alpha_ok  (alpha_ok)
  );

  sti_classify u_classify (
    .char_byte (in_byte_r),
    .alphabet  (alphabet),
    .alpha_len (alpha_len),
    .cls       (cls)
  );

  assign fire     = in_vld_r && (!cls.term || !out_vld_r || out_ready);
  assign emit     = fire && cls.term;
  assign in_ready = !in_vld_r || fire;
  assign in_take  = in_valid && in_ready;
  assign mac      = sti_pkg::ACC_W'(acc_r * sti_pkg::ACC_W'(alpha_len)) +
                    sti_pkg::ACC_W'(cls.digit);

  always_comb begin
    in_vld_nxt     = in_take || (in_vld_r && !fire);
    phase_nxt      = phase_r;
    acc_nxt        = acc_r;
    neg_nxt        = neg_r;
    out_vld_nxt    = out_vld_r && !out_ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    if (emit) begin
      out_vld_nxt = 1'b1;
      phase_nxt   = PH_SPACE;
      acc_nxt     = '0;
      neg_nxt     = 1'b0;
      priority if (!alpha_ok) begin
        out_value_nxt  = '0;
        out_status_nxt = sti_pkg::ST_BAD_ALPHABET;
      end else if (phase_r == PH_STRAY) begin
        out_value_nxt  = '0;
        out_status_nxt = sti_pkg::ST_STRAY;
      end else begin
        out_value_nxt  = neg_r ? (sti_pkg::ACC_W'(0) - acc_r) : acc_r;
        out_status_nxt = sti_pkg::ST_OK;
      end
    end else if (fire) begin
      unique case (phase_r)
        PH_SPACE, PH_SIGN: begin
          priority if (cls.space && (phase_r == PH_SPACE)) begin
            phase_nxt = PH_SPACE;
          end else if (cls.minus) begin
            phase_nxt = PH_SIGN;
            neg_nxt   = !neg_r;
          end else if (cls.plus) begin
            phase_nxt = PH_SIGN;
          end else if (cls.hit) begin
            phase_nxt = PH_DIGIT;
            acc_nxt   = mac;
          end else begin
            phase_nxt = PH_STRAY;
          end
        end
        PH_DIGIT: begin
          if (cls.hit) begin
            acc_nxt = mac;
          end else begin
            phase_nxt = PH_STRAY;
          end
        end
        PH_STRAY: phase_nxt = PH_STRAY;
        default:  phase_nxt = PH_STRAY;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      phase_r   <= PH_SPACE;
      acc_r     <= '0;
      neg_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      phase_r   <= phase_nxt;
      acc_r     <= acc_nxt;
      neg_r     <= neg_nxt;
      out_vld_r <= out_vld_nxt;
    end
    if (in_take) begin
      in_byte_r <= in_char_byte;
    end
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid  = out_vld_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

  // error results carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_status_r != sti_pkg::ST_OK)) |-> (out_value_r == '0))
    else $error("error word with nonzero value");

  // a terminator leaves the parse state cleared
  a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> ((phase_r == PH_SPACE) && (acc_r == '0) && !neg_r))
    else $error("parse state not cleared after terminator");

  // stray state holds until the terminator
  a_stray_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ((phase_r == PH_STRAY) && !emit) |=> (phase_r == PH_STRAY))
    else $error("left stray state without terminator");

  // a held result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_ready) |-> !emit)
    else $error("result overwritten while held");

  // input stage stalls only when occupied
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> in_vld_r)
    else $error("input stalled while empty");

endmodule

[hdl/sti_cfg_regs.sv]
// register port holding the digit alphabet, with a registered validity check
module sti_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sti_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [sti_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [sti_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready,
  output sti_pkg::alphabet_t                 alphabet,
  output logic [sti_pkg::LEN_W-1:0]          alpha_len,
  output logic                               alpha_ok
);

  logic [sti_pkg::HALF_W-1:0] alpha_low_r;
  logic [sti_pkg::HALF_W-1:0] alpha_high_r;
  logic [sti_pkg::LEN_W-1:0]  alpha_len_r;
  logic                       alpha_ok_r;
  logic                       alpha_ok_nxt;
  logic                       wr_en;
  sti_pkg::reg_idx_t          reg_idx;
  sti_pkg::alphabet_t         alpha;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = sti_pkg::reg_idx_t'(paddr[sti_pkg::APB_ADDR_W-1 -: sti_pkg::REG_IDX_W]);
  assign alpha   = {alpha_high_r, alpha_low_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_low_r  <= '0;
      alpha_high_r <= '0;
      alpha_len_r  <= '0;
      alpha_ok_r   <= 1'b0;
    end else begin
      alpha_ok_r <= alpha_ok_nxt;
      if (wr_en) begin
        unique case (reg_idx)
          sti_pkg::REG_ALPHA_LOW:  alpha_low_r  <= pwdata[sti_pkg::HALF_W-1:0];
          sti_pkg::REG_ALPHA_HIGH: alpha_high_r <= pwdata[sti_pkg::HALF_W-1:0];
          sti_pkg::REG_ALPHA_LEN:  alpha_len_r  <= pwdata[sti_pkg::LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (reg_idx)
      sti_pkg::REG_ALPHA_LOW:  prdata = alpha_low_r;
      sti_pkg::REG_ALPHA_HIGH: prdata = alpha_high_r;
      sti_pkg::REG_ALPHA_LEN:  prdata = {{(sti_pkg::APB_DATA_W-sti_pkg::LEN_W){1'b0}}, alpha_len_r};
      default:                 prdata = '0;
    endcase
  end

  // pairwise compares run in parallel, result registered
  always_comb begin
    alpha_ok_nxt = (alpha_len_r >= sti_pkg::LEN_W'(2)) &&
                   (alpha_len_r <= sti_pkg::LEN_W'(sti_pkg::MAX_BASE));
    for (int i = 0; i < sti_pkg::MAX_BASE; i++) begin
      if (sti_pkg::LEN_W'(i) < alpha_len_r) begin
        if ((alpha[i] == sti_pkg::CHAR_NUL) || sti_pkg::is_space(alpha[i]) ||
            (alpha[i] == sti_pkg::CHAR_PLUS) || (alpha[i] == sti_pkg::CHAR_MINUS)) begin
          alpha_ok_nxt = 1'b0;
        end
        for (int j = i + 1; j < sti_pkg::MAX_BASE; j++) begin
          if ((sti_pkg::LEN_W'(j) < alpha_len_r) && (alpha[j] == alpha[i])) begin
            alpha_ok_nxt = 1'b0;
          end
        end
      end
    end
  end

  assign alphabet  = alpha;
  assign alpha_len = alpha_len_r;
  assign alpha_ok  = alpha_ok_r;

endmodule

[hdl/sti_classify.sv]
// sorts one byte into terminator, whitespace, sign or alphabet digit
module sti_classify (
  input  logic [sti_pkg::CHAR_W-1:0] char_byte,
  input  sti_pkg::alphabet_t         alphabet,
  input  logic [sti_pkg::LEN_W-1:0]  alpha_len,
  output sti_pkg::char_class_t       cls
);

  logic                      hit;
  logic [sti_pkg::DIG_W-1:0] digit;

  // lowest matching position wins
  always_comb begin
    hit   = 1'b0;
    digit = '0;
    for (int i = sti_pkg::MAX_BASE - 1; i >= 0; i--) begin
      if ((sti_pkg::LEN_W'(i) < alpha_len) && (alphabet[i] == char_byte)) begin
        hit   = 1'b1;
        digit = sti_pkg::DIG_W'(i);
      end
    end
  end

  assign cls.term  = (char_byte == sti_pkg::CHAR_NUL);
  assign cls.space = sti_pkg::is_space(char_byte);
  assign cls.plus  = (char_byte == sti_pkg::CHAR_PLUS);
  assign cls.minus = (char_byte == sti_pkg::CHAR_MINUS);
  assign cls.hit   = hit;
  assign cls.digit = digit;

endmodule
